>>> rtl/core/pat_pkg.sv
// shared types and codes for the positional array table
package pat_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 7;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_MISS   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_ROTATE,
    CM_ROT_REPLACE,
    CM_DELETE
  } cell_mode_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_mode_t       mode;
    logic [POS_W-1:0] pos_idx;
    logic [POS_W-1:0] tail_idx;
  } cell_ctrl_t;

endpackage

>>> rtl/core/pat_if.sv
// valid/ready channel interfaces for the positional array table

interface pat_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       op;
  logic [pat_pkg::POS_W-1:0]        position;
  logic signed [pat_pkg::WORD_W-1:0] value;
  logic signed [pat_pkg::WORD_W-1:0] search_key;

  modport source (output valid, op, position, value, search_key, input ready);
  modport sink   (input valid, op, position, value, search_key, output ready);
endinterface

interface pat_out_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       status;
  logic [pat_pkg::POS_W-1:0]        found_position;
  logic signed [pat_pkg::WORD_W-1:0] data;
  logic [pat_pkg::POS_W-1:0]        count;
  logic                             last;

  modport source (output valid, status, found_position, data, count, last, input ready);
  modport sink   (input valid, status, found_position, data, count, last, output ready);
endinterface

>>> rtl/core/pat_cell.sv
// one storage cell of the table chain, holding a single word
module pat_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  pat_pkg::cell_ctrl_t          ctrl,
  input  logic [pat_pkg::WORD_W-1:0]   value,
  input  logic [pat_pkg::WORD_W-1:0]   left_word,
  input  logic [pat_pkg::WORD_W-1:0]   right_word,
  input  logic [pat_pkg::WORD_W-1:0]   head_word,
  output logic [pat_pkg::WORD_W-1:0]   word
);

  localparam logic [pat_pkg::POS_W-1:0] MY_IDX = pat_pkg::POS_W'(IDX);

  logic [pat_pkg::WORD_W-1:0] word_r;
  logic [pat_pkg::WORD_W-1:0] word_nxt;

  // next word from the broadcast command and the neighbours
  always_comb begin
    word_nxt = word_r;
    case (ctrl.mode)
      pat_pkg::CM_INSERT: begin
        if (MY_IDX == ctrl.pos_idx) begin
          word_nxt = value;
        end else if (MY_IDX > ctrl.pos_idx) begin
          word_nxt = left_word;
        end
      end
      pat_pkg::CM_ROTATE, pat_pkg::CM_ROT_REPLACE: begin
        if (MY_IDX == ctrl.tail_idx) begin
          word_nxt = (ctrl.mode == pat_pkg::CM_ROT_REPLACE) ? value : head_word;
        end else if (MY_IDX < ctrl.tail_idx) begin
          word_nxt = right_word;
        end
      end
      pat_pkg::CM_DELETE: begin
        if (MY_IDX >= ctrl.pos_idx) begin
          word_nxt = right_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // word storage, no reset needed
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

>>> rtl/core/positional_array_table.sv
// top level of the positional array table: control sequencer and cell chain

// The table keeps up to DEPTH signed words in a row of cells, entry 1 in cell 0.
// Insert and every rejected request pass through the emit state before the next
// item is accepted, and an unused op code is dropped while idle. Search and update
// rotate the stored words once round the chain, one cell a cycle, then emit;
// delete adds a shift state between rotation and emit. Dump emits one result per
// rotation step, and its rotation holds while the output register cannot take a
// result. Every word passes the single head cell during rotation. A result waits
// in the output register while the next item is accepted. No clearing pass runs
// after reset.
module positional_array_table #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  pat_in_if.sink           in_chan,
  pat_out_if.source        out_chan
);

  localparam int PW = pat_pkg::POS_W;
  localparam int WW = pat_pkg::WORD_W;
  localparam logic [PW-1:0] DEPTH_C = PW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [PW-1:0]     count_r;
  logic [PW-1:0]     k_r;
  logic              hit_r;
  pat_pkg::op_t      cmd_op_r;
  logic [PW-1:0]     cmd_pos_r;
  logic [WW-1:0]     cmd_value_r;
  logic [WW-1:0]     cmd_key_r;
  pat_pkg::status_t  res_status_r;
  logic [PW-1:0]     res_pos_r;
  logic [WW-1:0]     res_data_r;

  logic              out_valid_r;
  pat_pkg::status_t  out_status_r;
  logic [PW-1:0]     out_pos_r;
  logic [WW-1:0]     out_data_r;
  logic [PW-1:0]     out_count_r;
  logic              out_last_r;

  logic [WW-1:0]     words [DEPTH];
  logic [WW-1:0]     head_word;
  pat_pkg::cell_ctrl_t ctrl;
  logic [WW-1:0]     cell_value;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              step_en;
  logic [PW-1:0]     tail_idx;
  logic              at_tail;
  logic              at_target;
  logic              key_hit;

  // accept decode
  pat_pkg::op_t      in_op;
  logic              op_valid;
  logic              acc_rot;
  logic              acc_ins_ok;
  pat_pkg::status_t  acc_status;

  assign in_chan.ready = (state_r == S_IDLE) && rst_n;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign head_word     = words[0];
  assign tail_idx      = count_r - PW'(1);
  assign at_tail       = (k_r == tail_idx);
  assign at_target     = (k_r == cmd_pos_r - PW'(1));
  assign key_hit       = (head_word == cmd_key_r);
  assign step_en       = (cmd_op_r == pat_pkg::OP_DUMP) ? out_free : 1'b1;
  assign in_op         = pat_pkg::op_t'(in_chan.op);

  // output register loads a new item this cycle
  assign out_load = ((state_r == S_ROT) && (cmd_op_r == pat_pkg::OP_DUMP) && step_en) ||
                    ((state_r == S_EMIT) && out_free);

  // classify the incoming request against the current count
  always_comb begin
    op_valid   = 1'b1;
    acc_rot    = 1'b0;
    acc_ins_ok = 1'b0;
    acc_status = pat_pkg::ST_OK;
    case (in_op)
      pat_pkg::OP_INSERT: begin
        if (count_r >= DEPTH_C) begin
          acc_status = pat_pkg::ST_FULL;
        end else if (in_chan.position == '0 || in_chan.position > count_r + PW'(1)) begin
          acc_status = pat_pkg::ST_BADPOS;
        end else begin
          acc_ins_ok = 1'b1;
        end
      end
      pat_pkg::OP_DELETE, pat_pkg::OP_UPDATE: begin
        if (count_r == '0) begin
          acc_status = pat_pkg::ST_EMPTY;
        end else if (in_chan.position == '0 || in_chan.position > count_r) begin
          acc_status = pat_pkg::ST_BADPOS;
        end else begin
          acc_rot = 1'b1;
        end
      end
      pat_pkg::OP_SEARCH, pat_pkg::OP_DUMP: begin
        if (count_r == '0) begin
          acc_status = pat_pkg::ST_EMPTY;
        end else begin
          acc_rot = 1'b1;
        end
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase
  end

  // command to the cell chain
  always_comb begin
    ctrl.mode     = pat_pkg::CM_HOLD;
    ctrl.tail_idx = tail_idx;
    ctrl.pos_idx  = cmd_pos_r - PW'(1);
    cell_value    = cmd_value_r;
    case (state_r)
      S_IDLE: begin
        ctrl.pos_idx = in_chan.position - PW'(1);
        cell_value   = in_chan.value;
        if (in_fire && acc_ins_ok) begin
          ctrl.mode = pat_pkg::CM_INSERT;
        end
      end
      S_ROT: begin
        if (step_en) begin
          if (cmd_op_r == pat_pkg::OP_UPDATE && at_target) begin
            ctrl.mode = pat_pkg::CM_ROT_REPLACE;
          end else begin
            ctrl.mode = pat_pkg::CM_ROTATE;
          end
        end
      end
      S_SHIFT: begin
        ctrl.mode = pat_pkg::CM_DELETE;
      end
      default: begin
        ctrl.mode = pat_pkg::CM_HOLD;
      end
    endcase
  end

  // row of cells, each wired to its neighbours and the head cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WW-1:0] left_w;
    logic [WW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    pat_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (cell_value),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (head_word),
      .word       (words[i])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      hit_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && op_valid) begin
            cmd_op_r     <= in_op;
            cmd_pos_r    <= in_chan.position;
            cmd_value_r  <= in_chan.value;
            cmd_key_r    <= in_chan.search_key;
            res_status_r <= acc_status;
            res_pos_r    <= '0;
            res_data_r   <= '0;
            k_r          <= '0;
            hit_r        <= 1'b0;
            if (acc_ins_ok) begin
              count_r <= count_r + PW'(1);
            end
            state_r <= acc_rot ? S_ROT : S_EMIT;
          end
        end
        S_ROT: begin
          if (step_en) begin
            k_r <= k_r + PW'(1);
            // first matching entry wins
            if (cmd_op_r == pat_pkg::OP_SEARCH && !hit_r && key_hit) begin
              hit_r     <= 1'b1;
              res_pos_r <= k_r + PW'(1);
            end
            if ((cmd_op_r == pat_pkg::OP_UPDATE || cmd_op_r == pat_pkg::OP_DELETE)
                && at_target) begin
              res_data_r <= head_word;
            end
            if (cmd_op_r == pat_pkg::OP_DUMP) begin
              out_valid_r  <= 1'b1;
              out_status_r <= pat_pkg::ST_OK;
              out_pos_r    <= k_r + PW'(1);
              out_data_r   <= head_word;
              out_count_r  <= count_r;
              out_last_r   <= at_tail;
            end
            if (at_tail) begin
              if (cmd_op_r == pat_pkg::OP_SEARCH) begin
                res_status_r <= (hit_r || key_hit) ? pat_pkg::ST_OK : pat_pkg::ST_MISS;
              end
              case (cmd_op_r)
                pat_pkg::OP_DUMP:   state_r <= S_IDLE;
                pat_pkg::OP_DELETE: state_r <= S_SHIFT;
                default:            state_r <= S_EMIT;
              endcase
            end
          end
        end
        S_SHIFT: begin
          count_r <= count_r - PW'(1);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= res_pos_r;
            out_data_r   <= res_data_r;
            out_count_r  <= count_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.found_position = out_pos_r;
  assign out_chan.data           = out_data_r;
  assign out_chan.count          = out_count_r;
  assign out_chan.last           = out_last_r;

`ifndef NO_ASSERTIONS
  // count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stored count above capacity");

  // rotation only runs over a non-empty table
  a_rot_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROT |-> count_r != '0)
    else $error("rotation with empty table");

  // a result without the last flag only comes from a dump
  a_last_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> cmd_op_r == pat_pkg::OP_DUMP)
    else $error("non-final result outside a dump");

  // the delete shift removes exactly one entry
  a_shift_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |=> count_r == $past(count_r) - PW'(1))
    else $error("delete did not decrement count");
`endif

endmodule

>>> tb/sv/positional_array_table_chk.sv
`timescale 1ns / 1ps
// checker for the positional array table: shadow table, result prediction and comparison
module positional_array_table_chk
  import pat_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  pat_in_if    in_mon,
  pat_out_if   out_mon,
  output int   mismatches,
  output int   awaited,
  output int   results_seen
);

  // one expected result item
  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   slot;
    logic [WORD_W-1:0]  word;
    logic [POS_W-1:0]   fill;
    logic               last;
  } table_result_t;

  // shadow copy of the stored words and their count
  logic [WORD_W-1:0] shadow_words [DEPTH];
  int                shadow_fill;
  table_result_t     pending_results [$];

  // queue a result carrying the count as it stands after the operation
  task automatic queue_result(input status_t status, input int slot,
                              input logic [WORD_W-1:0] word, input logic last);
    table_result_t r;
    r.status = status;
    r.slot   = slot[POS_W-1:0];
    r.word   = word;
    r.fill   = shadow_fill[POS_W-1:0];
    r.last   = last;
    pending_results.push_back(r);
  endtask

  // apply one accepted request to the shadow table and queue its results
  task automatic predict_table_op(input logic [2:0] op, input int pos,
                                  input logic [WORD_W-1:0] val,
                                  input logic [WORD_W-1:0] key);
    logic [WORD_W-1:0] old_word;
    int                hit;
    case (op)
      OP_INSERT: begin
        // fullness wins over a bad position
        if (shadow_fill >= DEPTH) begin
          queue_result(ST_FULL, 0, '0, 1'b1);
        end else if (pos < 1 || pos > shadow_fill + 1) begin
          queue_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = shadow_fill; i >= pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos-1] = val;
          shadow_fill++;
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (shadow_fill == 0) begin
          queue_result(ST_EMPTY, 0, '0, 1'b1);
        end else if (pos < 1 || pos > shadow_fill) begin
          queue_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          old_word = shadow_words[pos-1];
          for (int i = pos - 1; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
          queue_result(ST_OK, 0, old_word, 1'b1);
        end
      end
      OP_UPDATE: begin
        if (shadow_fill == 0) begin
          queue_result(ST_EMPTY, 0, '0, 1'b1);
        end else if (pos < 1 || pos > shadow_fill) begin
          queue_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          old_word = shadow_words[pos-1];
          shadow_words[pos-1] = val;
          queue_result(ST_OK, 0, old_word, 1'b1);
        end
      end
      OP_SEARCH: begin
        // first matching slot only
        hit = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (hit == 0 && shadow_words[i] == key) hit = i + 1;
        end
        if (shadow_fill == 0) queue_result(ST_EMPTY, 0, '0, 1'b1);
        else if (hit != 0) queue_result(ST_OK, hit, '0, 1'b1);
        else queue_result(ST_MISS, 0, '0, 1'b1);
      end
      OP_DUMP: begin
        if (shadow_fill == 0) queue_result(ST_EMPTY, 0, '0, 1'b1);
        for (int i = 0; i < shadow_fill; i++) begin
          queue_result(ST_OK, i + 1, shadow_words[i], i + 1 == shadow_fill);
        end
      end
      default: begin
        // unused op codes are dropped without a result
      end
    endcase
  endtask

  task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare one result item with the oldest expectation
  task automatic check_result();
    table_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected, status %0d slot %0d data %h count %0d last %b",
               $time, out_mon.status, out_mon.found_position, out_mon.data, out_mon.count,
               out_mon.last);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      results_seen++;
      report_field("status", WORD_W'(want.status), WORD_W'(out_mon.status));
      report_field("found_position", WORD_W'(want.slot), WORD_W'(out_mon.found_position));
      report_field("data", want.word, out_mon.data);
      report_field("count", WORD_W'(want.fill), WORD_W'(out_mon.count));
      report_field("last", WORD_W'(want.last), WORD_W'(out_mon.last));
    end
  endtask

  initial begin
    shadow_fill  = 0;
    mismatches   = 0;
    awaited      = 0;
    results_seen = 0;
  end

  // results are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) begin
        predict_table_op(in_mon.op, in_mon.position, in_mon.value, in_mon.search_key);
      end
      awaited = pending_results.size();
    end
  end

endmodule

>>> tb/sv/positional_array_table_tb.sv
`timescale 1ns / 1ps
// testbench top for the positional array table: clock, reset, stimulus and verdict
module positional_array_table_tb;
  import pat_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   awaited;
  int   results_seen;
  int   quiet_cycles = 0;

  // stimulus bookkeeping: words held, for choosing positions and keys
  int                fill        = 0;
  int                peak_fill   = 0;
  int                full_rejects = 0;
  int                burst_left  = 0;
  int                op_tally [8];
  logic [WORD_W-1:0] recent_words [$];

  pat_in_if  in_chan ();
  pat_out_if out_chan ();

  positional_array_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  positional_array_table_chk #(.DEPTH(TABLE_DEPTH)) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure, cycling through four ready patterns, one of them never stalling
  initial begin
    int unsigned beat;
    out_chan.ready = 1'b0;
    beat = 0;
    forever begin
      @(negedge clk);
      beat++;
      case (beat[8:7])
        2'd0: out_chan.ready <= 1'b1;
        2'd1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_chan.ready <= (beat[2:0] != 3'd0) && (beat[2:0] != 3'd3);
        default: out_chan.ready <= (beat[4:2] != 3'd5);
      endcase
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: begin
        if (recent_words.size() > 0) begin
          return recent_words[$urandom_range(0, recent_words.size() - 1)];
        end
      end
      default: ;
    endcase
    return $urandom();
  endfunction

  // keys lean towards words already stored so that searches hit
  function automatic logic [WORD_W-1:0] pick_key();
    if ($urandom_range(0, 1) == 1 && recent_words.size() > 0) begin
      return recent_words[$urandom_range(0, recent_words.size() - 1)];
    end
    return pick_word();
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_item(input logic [2:0] op, input int pos,
                           input logic [WORD_W-1:0] val, input logic [WORD_W-1:0] key);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_chan.valid      <= 1'b1;
    in_chan.op         <= op;
    in_chan.position   <= pos[POS_W-1:0];
    in_chan.value      <= val;
    in_chan.search_key <= key;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    op_tally[op]++;
    // follow the word count so that later positions can be chosen in range
    if (op == OP_INSERT) begin
      if (fill == TABLE_DEPTH) begin
        full_rejects++;
      end else if (pos >= 1 && pos <= fill + 1) begin
        fill++;
        recent_words.push_back(val);
      end
    end else if (op == OP_DELETE && fill > 0 && pos >= 1 && pos <= fill) begin
      fill--;
    end else if (op == OP_UPDATE && fill > 0 && pos >= 1 && pos <= fill) begin
      recent_words.push_back(val);
    end
    if (recent_words.size() > 40) void'(recent_words.pop_front());
    if (fill > peak_fill) peak_fill = fill;
  endtask

  // sender holds off until every expected result item is back
  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
  endtask

  // weighted random request; noise covers unused ops and any position
  task automatic random_item(input int w_ins, input int w_del, input int w_upd,
                             input int w_srch, input int w_dump, input int w_noise);
    int         roll;
    int         pos;
    logic [2:0] op;
    roll = $urandom_range(0, w_ins + w_del + w_upd + w_srch + w_dump + w_noise - 1);
    pos  = (fill == 0) ? $urandom_range(0, 127) : $urandom_range(1, fill);
    if (roll < w_ins) begin
      op  = OP_INSERT;
      pos = $urandom_range(1, fill + 1);
    end else if (roll < w_ins + w_del) begin
      op = OP_DELETE;
    end else if (roll < w_ins + w_del + w_upd) begin
      op = OP_UPDATE;
    end else if (roll < w_ins + w_del + w_upd + w_srch) begin
      op = OP_SEARCH;
    end else if (roll < w_ins + w_del + w_upd + w_srch + w_dump) begin
      op = OP_DUMP;
    end else begin
      op  = 3'($urandom_range(0, 7));
      pos = $urandom_range(0, 127);
    end
    push_item(op, pos, pick_word(), pick_key());
  endtask

  initial begin
    in_chan.valid      = 1'b0;
    in_chan.op         = OP_INSERT;
    in_chan.position   = '0;
    in_chan.value      = '0;
    in_chan.search_key = '0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table
    push_item(OP_DUMP, 0, '0, '0);
    push_item(OP_DELETE, 1, '0, '0);
    push_item(OP_UPDATE, 127, 32'h1234_5678, '0);
    push_item(OP_SEARCH, 0, '0, '0);
    push_item(OP_INSERT, 0, 32'h1, '0);
    push_item(OP_INSERT, 2, 32'h1, '0);
    // build a short table: extremes, front, middle, tail and a duplicate
    push_item(OP_INSERT, 1, 32'h8000_0000, '0);
    push_item(OP_INSERT, 2, 32'h7fff_ffff, '0);
    push_item(OP_INSERT, 1, 32'hffff_ffff, '0);
    push_item(OP_INSERT, 2, 32'h0, '0);
    push_item(OP_INSERT, 5, 32'h0, '0);
    push_item(OP_INSERT, 127, 32'h5555_5555, '0);
    // search hits the first of two equal words, then a single word, then a miss
    push_item(OP_SEARCH, 0, '0, 32'h0);
    push_item(OP_SEARCH, 0, '0, 32'h7fff_ffff);
    push_item(OP_SEARCH, 0, '0, 32'h1234_5678);
    push_item(OP_UPDATE, 0, 32'h1, '0);
    push_item(OP_UPDATE, 6, 32'h1, '0);
    push_item(OP_UPDATE, 3, 32'haaaa_aaaa, '0);
    push_item(OP_DELETE, 6, '0, '0);
    push_item(OP_DELETE, 1, '0, '0);
    push_item(OP_DELETE, 4, '0, '0);
    push_item(OP_DUMP, 0, '0, '0);
    for (int u = FIRST_UNUSED_OP; u < 8; u++) push_item(u[2:0], 1, 32'hffff_ffff, '0);
    hold_until_drained();

    // random: general mix
    repeat (30) random_item(4, 2, 2, 2, 1, 1);

    // fill to capacity, then press on the full table
    while (fill < TABLE_DEPTH) random_item(12, 0, 1, 1, 0, 0);
    push_item(OP_INSERT, 1, pick_word(), '0);
    push_item(OP_INSERT, TABLE_DEPTH + 1, pick_word(), '0);
    push_item(OP_INSERT, 0, pick_word(), '0);
    push_item(OP_SEARCH, 0, '0, pick_key());
    push_item(OP_DUMP, 0, '0, '0);
    push_item(OP_UPDATE, TABLE_DEPTH, pick_word(), '0);
    push_item(OP_UPDATE, TABLE_DEPTH + 1, pick_word(), '0);
    push_item(OP_DELETE, TABLE_DEPTH + 1, '0, '0);
    hold_until_drained();

    // drain to empty with searches, updates and dumps mixed in
    while (fill > 0) random_item(1, 9, 1, 2, 1, 1);
    push_item(OP_DELETE, 1, '0, '0);
    push_item(OP_DUMP, 0, '0, '0);
    hold_until_drained();

    repeat (15) random_item(4, 3, 2, 2, 1, 1);

    // wind down: every result back, then let any late item show itself
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d items: %0d insert, %0d delete, %0d update, %0d search, %0d dump",
             op_tally.sum(), op_tally[OP_INSERT], op_tally[OP_DELETE], op_tally[OP_UPDATE],
             op_tally[OP_SEARCH], op_tally[OP_DUMP]);
    $display("  and %0d unused op codes", op_tally[5] + op_tally[6] + op_tally[7]);
    $display("checked %0d results; table reached %0d of %0d words, %0d inserts refused as full",
             results_seen, peak_fill, TABLE_DEPTH, full_rejects);
    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pat_pkg.sv
rtl/core/pat_if.sv
rtl/core/pat_cell.sv
rtl/core/positional_array_table.sv
tb/sv/positional_array_table_chk.sv
tb/sv/positional_array_table_tb.sv
